// ----- rtl/nmea_fx_pkg.sv -----
package nmea_fx_pkg;

    // Received characters of interest
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_G      = 8'h47;
    localparam logic [7:0] CHAR_M      = 8'h4D;

    // Bytes after '$' at which the sentence type is decided
    localparam int unsigned POS_W         = 3;
    localparam logic [POS_W-1:0] POS_MAX  = 3'd7;
    localparam logic [POS_W-1:0] POS_TYPE = 3'd4;

    localparam int unsigned FNUM_W = 4;
    localparam int unsigned CPOS_W = 5;
    localparam int unsigned FID_W  = 4;
    localparam int unsigned IDX_W  = 4;

    localparam logic [FNUM_W-1:0] FNUM_MAX = 4'd15;
    localparam logic [CPOS_W-1:0] CPOS_MAX = 5'd31;
    localparam logic [IDX_W-1:0]  IDX_MAX  = 4'd15;

    // GGA and RMC field numbers that are kept, and their ids
    localparam logic [FNUM_W-1:0] GGA_FNUM_SATS = 4'd7;
    localparam logic [FNUM_W-1:0] GGA_FNUM_ALT  = 4'd9;
    localparam logic [FNUM_W-1:0] RMC_FNUM_LO   = 4'd1;
    localparam logic [FNUM_W-1:0] RMC_FNUM_HI   = 4'd9;

    localparam logic [FID_W-1:0] FID_STATUS = 4'd1;
    localparam logic [FID_W-1:0] FID_NS     = 4'd3;
    localparam logic [FID_W-1:0] FID_EW     = 4'd5;
    localparam logic [FID_W-1:0] FID_SATS   = 4'd9;
    localparam logic [FID_W-1:0] FID_ALT    = 4'd10;

    // Sentence tracking state, one-hot
    typedef enum logic [3:0] {
        KIND_IDLE  = 4'b0001,
        KIND_START = 4'b0010,
        KIND_GGA   = 4'b0100,
        KIND_RMC   = 4'b1000
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [POS_W-1:0]   pos;
        logic [FNUM_W-1:0]  fnum;
        logic [CPOS_W-1:0]  cpos;
    } parse_state_t;

    typedef struct packed {
        logic               store_valid;
        logic [FID_W-1:0]   field_id;
        logic [IDX_W-1:0]   char_index;
        logic [7:0]         char_value;
        logic               index_overflow;
        logic               sentence_done;
        logic               in_sentence;
    } store_rec_t;

endpackage

// ----- rtl/nmea_fx_step.sv -----
module nmea_fx_step #(
    parameter int unsigned FIELD_CAPACITY = 16
) (
    input  nmea_fx_pkg::parse_state_t cur,
    input  logic [7:0]                rx_byte,
    output nmea_fx_pkg::parse_state_t nxt,
    output nmea_fx_pkg::store_rec_t   rec
);
    import nmea_fx_pkg::*;

    logic [POS_W-1:0] pos_inc;
    logic             map_hit;
    logic [FID_W-1:0] map_id;
    logic             single_char;
    logic             cpos_ovf;

    // Saturating byte count since '$'
    assign pos_inc = (cur.pos == POS_MAX) ? POS_MAX : cur.pos + 1'b1;

    // Map field number to field id for the current sentence type
    always_comb
    begin
        map_hit = 1'b0;
        map_id  = '0;
        if (cur.kind == KIND_GGA)
        begin
            if (cur.fnum == GGA_FNUM_SATS)
            begin
                map_hit = 1'b1;
                map_id  = FID_SATS;
            end
            else if (cur.fnum == GGA_FNUM_ALT)
            begin
                map_hit = 1'b1;
                map_id  = FID_ALT;
            end
        end
        else if (cur.kind == KIND_RMC && cur.fnum >= RMC_FNUM_LO && cur.fnum <= RMC_FNUM_HI)
        begin
            map_hit = 1'b1;
            map_id  = cur.fnum - 1'b1;
        end
    end

    assign single_char = (map_id == FID_STATUS) || (map_id == FID_NS) || (map_id == FID_EW);
    assign cpos_ovf    = {1'b0, cur.cpos} >= (CPOS_W + 1)'(FIELD_CAPACITY);

    // Advance the parser by one byte and build the store record
    always_comb
    begin
        nxt     = cur;
        nxt.pos = pos_inc;
        rec     = '0;
        if (cur.kind != KIND_IDLE)
        begin
            if (pos_inc == POS_TYPE)
            begin
                if (rx_byte == CHAR_G)
                    nxt.kind = KIND_GGA;
                else if (rx_byte == CHAR_M)
                    nxt.kind = KIND_RMC;
                else
                begin
                    nxt.kind = KIND_IDLE;
                    nxt.pos  = '0;
                    nxt.fnum = '0;
                end
            end
            else if (rx_byte == CHAR_COMMA)
            begin
                if (cur.fnum != FNUM_MAX)
                    nxt.fnum = cur.fnum + 1'b1;
                nxt.cpos = '0;
            end
            else if (rx_byte == CHAR_LF || rx_byte == CHAR_CR)
            begin
                nxt.pos           = '0;
                rec.sentence_done = (cur.kind == KIND_RMC);
                nxt.kind          = KIND_IDLE;
            end
            else if (cur.kind == KIND_GGA || cur.kind == KIND_RMC)
            begin
                if (map_hit)
                begin
                    rec.field_id   = map_id;
                    rec.char_value = rx_byte;
                    if (single_char)
                        rec.store_valid = 1'b1;
                    else
                    begin
                        rec.char_index = (cur.cpos > CPOS_W'(IDX_MAX)) ? IDX_MAX
                                                                         : cur.cpos[IDX_W-1:0];
                        rec.index_overflow = cpos_ovf;
                        rec.store_valid    = !cpos_ovf;
                    end
                end
                if (cur.cpos != CPOS_MAX)
                    nxt.cpos = cur.cpos + 1'b1;
            end
        end
        else if (rx_byte == CHAR_DOLLAR)
        begin
            nxt.kind = KIND_START;
            nxt.fnum = '0;
            nxt.pos  = '0;
            nxt.cpos = '0;
        end
        rec.in_sentence = (nxt.kind != KIND_IDLE);
    end

endmodule

// ----- rtl/nmea_gga_rmc_field_extractor.sv -----
// A result item appears on the master side in the cycle after its byte is accepted.
// One byte per cycle while the master side is ready; the parser state register and the result register
// are updated in the same cycle, so bytes may arrive back to back.
// The slave side stalls only while a result item waits and the master side is not ready.
// Reset (rst_n low, asynchronous) returns the parser to idle and clears the result valid flag.
module nmea_gga_rmc_field_extractor #(
    parameter int unsigned FIELD_CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [3:0] field_id, [7:4] char_index,
                                        // [15:8] char_value, [16] in_sentence, [23:17] zero
    output logic [1:0]  m_axis_tuser,   // [0] store_valid, [1] index_overflow
    output logic        m_axis_tlast    // sentence_done
);
    import nmea_fx_pkg::*;

    parse_state_t state_reg;
    parse_state_t state_next;
    store_rec_t   rec_next;
    store_rec_t   rec_reg;
    logic         out_valid_reg;
    logic         in_fire;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    nmea_fx_step #(
        .FIELD_CAPACITY (FIELD_CAPACITY)
    ) u_step (
        .cur     (state_reg),
        .rx_byte (s_axis_tdata),
        .nxt     (state_next),
        .rec     (rec_next)
    );

    // Advance parser state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.kind <= KIND_IDLE;
            state_reg.pos  <= '0;
            state_reg.fnum <= '0;
            state_reg.cpos <= '0;
        end
        else if (in_fire)
            state_reg <= state_next;
    end

    // Hold the result item until the master side takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            rec_reg <= rec_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, rec_reg.in_sentence, rec_reg.char_value,
                            rec_reg.char_index, rec_reg.field_id};
    assign m_axis_tuser  = {rec_reg.index_overflow, rec_reg.store_valid};
    assign m_axis_tlast  = rec_reg.sentence_done;

    // A stored byte is never also flagged as overflowed
    a_store_xor_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(rec_reg.store_valid && rec_reg.index_overflow))
        else $error("store and overflow both set");

    // End of sentence closes the sentence
    a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rec_reg.sentence_done) |-> !rec_reg.in_sentence)
        else $error("sentence_done while still in sentence");

    // Stored field ids stay within the defined set
    a_fid_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rec_reg.store_valid) |-> (rec_reg.field_id <= FID_ALT))
        else $error("field id out of range");

    // Every accepted item yields a result item in the next cycle
    a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted item produced no result");

    // Parser state moves only on an accepted item
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(state_reg))
        else $error("parser state changed without input");

endmodule

// ----- test/nmea_field_checker.sv -----
module nmea_field_checker #(
    parameter int unsigned FIELD_CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // [3:0] field_id, [7:4] char_index,
                                        // [15:8] char_value, [16] in_sentence, [23:17] zero
    input  logic [1:0]  m_axis_tuser,   // [0] store_valid, [1] index_overflow
    input  logic        m_axis_tlast,   // sentence_done
    output int          failures,
    output int          pending
);
    import nmea_fx_pkg::*;

    typedef struct {
        logic               store;
        logic [FID_W-1:0]   fid;
        logic [IDX_W-1:0]   idx;
        logic [7:0]         val;
        logic               ovf;
        logic               done;
        logic               in_sent;
    } store_rec_exp_t;

    // Parser state mirrored from the block
    kind_t              kind     = KIND_IDLE;
    logic [7:0]         byte_pos = '0;
    logic [FNUM_W-1:0]  fnum     = '0;
    logic [CPOS_W-1:0]  cpos     = '0;

    store_rec_exp_t     expected_recs[$];
    int                 fail_count    = 0;
    int                 pending_count = 0;

    assign failures = fail_count;
    assign pending  = pending_count;

    // Advance the parser by one byte and return the store record it yields
    function automatic store_rec_exp_t parse_byte(input logic [7:0] b);
        store_rec_exp_t     r;
        logic               mapped;
        logic [FID_W-1:0]   fid;
        r        = '{default: '0};
        mapped   = 1'b0;
        fid      = '0;
        if (byte_pos != 8'hFF)
            byte_pos++;
        if (kind != KIND_IDLE)
        begin
            if (byte_pos == 8'd4)
            begin
                // Classify on the fourth byte after the dollar, abort otherwise
                if (b == CHAR_G)
                    kind = KIND_GGA;
                else if (b == CHAR_M)
                    kind = KIND_RMC;
                else
                begin
                    kind     = KIND_IDLE;
                    byte_pos = '0;
                    fnum     = '0;
                end
            end
            else if (b == CHAR_COMMA)
            begin
                if (fnum != FNUM_MAX)
                    fnum++;
                cpos = '0;
            end
            else if (b == CHAR_LF || b == CHAR_CR)
            begin
                byte_pos = '0;
                r.done   = (kind == KIND_RMC);
                kind     = KIND_IDLE;
            end
            else if (kind == KIND_GGA || kind == KIND_RMC)
            begin
                if (kind == KIND_GGA)
                begin
                    if (fnum == GGA_FNUM_SATS)
                    begin
                        mapped = 1'b1;
                        fid    = FID_SATS;
                    end
                    else if (fnum == GGA_FNUM_ALT)
                    begin
                        mapped = 1'b1;
                        fid    = FID_ALT;
                    end
                end
                else if (fnum >= RMC_FNUM_LO && fnum <= RMC_FNUM_HI)
                begin
                    mapped = 1'b1;
                    fid    = fnum - 1'b1;
                end
                if (mapped)
                begin
                    r.fid = fid;
                    r.val = b;
                    // One-character fields are rewritten in place
                    if (fid == FID_STATUS || fid == FID_NS || fid == FID_EW)
                        r.store = 1'b1;
                    else
                    begin
                        r.idx = (cpos > CPOS_W'(IDX_MAX)) ? IDX_MAX : cpos[IDX_W-1:0];
                        if (cpos >= FIELD_CAPACITY)
                            r.ovf = 1'b1;
                        else
                            r.store = 1'b1;
                    end
                end
                if (cpos != CPOS_MAX)
                    cpos++;
            end
        end
        else if (b == CHAR_DOLLAR)
        begin
            kind     = KIND_START;
            fnum     = '0;
            byte_pos = '0;
            cpos     = '0;
        end
        r.in_sent = (kind != KIND_IDLE);
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Sample at the falling edge: values are stable until the next rising edge
    always @(negedge clk)
    begin : watch
        store_rec_exp_t want;
        if (rst_n)
        begin
            // Compare the result item first; it belongs to an earlier byte
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_recs.size() == 0)
                begin
                    $error("result item with no byte outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_recs.pop_front();
                    check_field("store_valid", want.store, m_axis_tuser[0]);
                    check_field("field_id", want.fid, m_axis_tdata[3:0]);
                    check_field("char_index", want.idx, m_axis_tdata[7:4]);
                    check_field("char_value", want.val, m_axis_tdata[15:8]);
                    check_field("index_overflow", want.ovf, m_axis_tuser[1]);
                    check_field("sentence_done", want.done, m_axis_tlast);
                    check_field("in_sentence", want.in_sent, m_axis_tdata[16]);
                    check_field("tdata_pad", 0, m_axis_tdata[23:17]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_recs.push_back(parse_byte(s_axis_tdata));
            pending_count = expected_recs.size();
        end
    end

endmodule

// ----- test/nmea_gga_rmc_field_extractor_tb.sv -----
module nmea_gga_rmc_field_extractor_tb;
    import nmea_fx_pkg::*;

    localparam int unsigned FIELD_CAPACITY = 16;
    localparam int          RANDOM_BYTES   = 1200;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    int          failures;
    int          pending;

    logic [7:0]  rx_stream[$];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    nmea_gga_rmc_field_extractor #(
        .FIELD_CAPACITY(FIELD_CAPACITY)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    nmea_field_checker #(
        .FIELD_CAPACITY(FIELD_CAPACITY)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .failures      (failures),
        .pending       (pending)
    );

    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] field_char();
        int         pick;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            c = 8'($urandom_range(8'h30, 8'h5A));
        else if (pick < 97)
        begin
            // Any byte that keeps the field open
            c = 8'($urandom_range(0, 255));
            if (c == CHAR_COMMA || c == CHAR_CR || c == CHAR_LF)
                c = 8'h2E;
        end
        else
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            rx_stream.push_back(s[i]);
    endtask

    // Build one sentence: header, comma-separated fields, and in most cases a line end
    task automatic add_sentence(input bit long_field);
        int pick;
        int nfields;
        int len;
        rx_stream.push_back(CHAR_DOLLAR);
        add_text("GP");
        rx_stream.push_back(8'($urandom_range(8'h41, 8'h5A)));
        pick = $urandom_range(0, 19);
        if (pick < 9)
            rx_stream.push_back(CHAR_G);
        else if (pick < 18)
            rx_stream.push_back(CHAR_M);
        else
            rx_stream.push_back(8'($urandom_range(0, 255)));
        rx_stream.push_back(8'($urandom_range(8'h41, 8'h5A)));
        nfields = ($urandom_range(0, 9) < 7) ? $urandom_range(8, 14) : $urandom_range(0, 17);
        for (int f = 0; f < nfields; f++)
        begin
            rx_stream.push_back(CHAR_COMMA);
            pick = $urandom_range(0, 99);
            if (pick < 50)
                len = $urandom_range(0, 6);
            else if (pick < 85)
                len = $urandom_range(7, 15);
            else
                len = $urandom_range(16, 40);
            if (long_field && f == 1)
                len = 270;
            for (int i = 0; i < len; i++)
                rx_stream.push_back(field_char());
        end
        pick = $urandom_range(0, 19);
        if (pick < 9)
            rx_stream.push_back(CHAR_CR);
        else if (pick < 18)
            rx_stream.push_back(CHAR_LF);
        else if (pick == 18)
        begin
            rx_stream.push_back(CHAR_CR);
            rx_stream.push_back(CHAR_LF);
        end
    endtask

    // Receiver: random stalls plus one long hold-off that backs up the input
    initial
    begin : sink
        int cyc;
        int stall;
        bit quiet;
        cyc   = 0;
        stall = 0;
        quiet = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 128 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (cyc >= 1500 && cyc < 1900)
                m_axis_tready <= 1'b0;
            else if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0)
                    stall = gap_len();
            end
        end
    end

    // Sender: build the byte stream, then offer it item by item
    initial
    begin : source
        int  base;
        int  nsent;
        int  gap;
        bit  tx_quiet;
        tx_quiet = 1'b0;

        // Idle bytes, abort on classification, early end, dollar as data
        rx_stream.push_back(8'h00);
        rx_stream.push_back(8'hFF);
        add_text("A$GPX$G");
        rx_stream.push_back(CHAR_CR);
        add_text("$GPRM,$A");
        rx_stream.push_back(CHAR_LF);

        base  = rx_stream.size();
        nsent = 0;
        while (rx_stream.size() < base + RANDOM_BYTES)
        begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 5))
                    rx_stream.push_back(8'($urandom_range(0, 255)));
            add_sentence(nsent == 3);
            nsent++;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < rx_stream.size(); n++)
        begin
            if (n % 64 == 0)
                tx_quiet = ($urandom_range(0, 3) == 0);
            gap = tx_quiet ? 0 : gap_len();
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= rx_stream[n];
            // Hold until accepted
            @(negedge clk);
            while (!s_axis_tready)
                @(negedge clk);
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b0;

        // Drain outstanding results
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (failures == 0)
            $display("nmea_gga_rmc_field_extractor regression: pass");
        else
            $display("nmea_gga_rmc_field_extractor regression: fail");
        $finish;
    end

    initial
    begin : watchdog
        #4000000;
        $display("nmea_gga_rmc_field_extractor regression: fail");
        $finish;
    end

endmodule

// ----- nmea_gga_rmc_field_extractor.f -----
rtl/nmea_fx_pkg.sv
rtl/nmea_fx_step.sv
rtl/nmea_gga_rmc_field_extractor.sv
test/nmea_field_checker.sv
test/nmea_gga_rmc_field_extractor_tb.sv
